FILE: sv/uart_dual_ring_buffer_assert.svh
// Assertion macros for the dual ring buffer checker
`ifndef UART_DUAL_RING_BUFFER_ASSERT_SVH
`define UART_DUAL_RING_BUFFER_ASSERT_SVH

// same-cycle implication
`define UDRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define UDRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/udrb_pkg.sv
// ----------------------------------------------------------------------------
// udrb_pkg
// Types, constants and address helpers of the dual serial ring buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udrb_pkg;

  localparam int DEPTH = 64;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SW    = CW + 1;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_RX       = 2'd2,
    OP_TX_READY = 2'd3
  } udrb_op_t;

  typedef struct packed {
    udrb_op_t    operation;
    logic [7:0]  data;
    logic [7:0]  block_size;
    logic        first;
  } udrb_in_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        ok;
    logic        last;
    logic        tx_request;
    logic [6:0]  tx_fill;
    logic [6:0]  rx_fill;
    logic [15:0] tx_drop_count;
    logic [15:0] rx_drop_count;
  } udrb_out_t;

  // base + off modulo DEPTH, valid for off <= DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) s = s - SW'(DEPTH);
    return s[AW-1:0];
  endfunction

endpackage

FILE: sv/udrb_ram.sv
// ----------------------------------------------------------------------------
// udrb_ram
// Byte store with one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/uart_dual_ring_buffer.sv
// ----------------------------------------------------------------------------
// uart_dual_ring_buffer
// Transmit and receive byte queues of a serial port with block admission.
// ----------------------------------------------------------------------------
// channel  | ports                      | handshake
// request  | start, busy, in_item       | taken when start && !busy
// result   | out_strobe, out_res        | one cycle per result, no back-pressure
//
// Every request gives its first result on the cycle after it is taken.
// A successful block read gives one byte per cycle from the receive memory;
// busy stays high until its last read is issued.
// All other requests leave busy low, and a new one may follow at once.
// Reset is synchronous; no clearing pass, the stores are valid only once written.
`timescale 1ns / 1ps

module uart_dual_ring_buffer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  udrb_pkg::udrb_in_t  in_item,
  output logic                out_strobe,
  output udrb_pkg::udrb_out_t out_res
);
  import udrb_pkg::*;

  typedef enum logic {ST_IDLE, ST_READ} state_t;
  typedef enum logic [1:0] {SRC_ZERO, SRC_TX, SRC_RX} src_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] tx_head_r, tx_head_nxt;
  logic [CW-1:0] tx_count_r, tx_count_nxt;
  logic [15:0]   tx_drops_r, tx_drops_nxt;
  logic [AW-1:0] rx_head_r, rx_head_nxt;
  logic [CW-1:0] rx_count_r, rx_count_nxt;
  logic [15:0]   rx_drops_r, rx_drops_nxt;
  logic          req_en_r, req_en_nxt;
  logic [7:0]    wr_rem_r, wr_rem_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [CW-1:0] rd_left_r, rd_left_nxt;
  logic          res_vld_r, res_vld_nxt;
  logic          res_ok_r, res_ok_nxt;
  logic          res_last_r, res_last_nxt;
  src_t          res_src_r, res_src_nxt;

  logic          tx_we, tx_re, rx_we, rx_re;
  logic [AW-1:0] tx_waddr, tx_raddr, rx_waddr, rx_raddr;
  logic [7:0]    tx_rdata, rx_rdata;
  logic [8:0]    tx_sum;
  logic          rd_ok;

  assign tx_sum = 9'(tx_count_r) + 9'(in_item.block_size);
  assign rd_ok  = (in_item.block_size != 8'd0)
               && (9'(rx_count_r) >= 9'(in_item.block_size))
               && (9'(in_item.block_size) <= 9'(DEPTH));

  always_comb begin
    state_nxt    = state_r;
    tx_head_nxt  = tx_head_r;
    tx_count_nxt = tx_count_r;
    tx_drops_nxt = tx_drops_r;
    rx_head_nxt  = rx_head_r;
    rx_count_nxt = rx_count_r;
    rx_drops_nxt = rx_drops_r;
    req_en_nxt   = req_en_r;
    wr_rem_nxt   = wr_rem_r;
    rd_addr_nxt  = rd_addr_r;
    rd_left_nxt  = rd_left_r;
    res_vld_nxt  = 1'b0;
    res_ok_nxt   = 1'b0;
    res_last_nxt = 1'b1;
    res_src_nxt  = SRC_ZERO;
    tx_we        = 1'b0;
    tx_waddr     = wrap_add(tx_head_r, tx_count_r);
    tx_re        = 1'b0;
    tx_raddr     = tx_head_r;
    rx_we        = 1'b0;
    rx_waddr     = wrap_add(rx_head_r, rx_count_r);
    rx_re        = 1'b0;
    rx_raddr     = rd_addr_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          res_vld_nxt = 1'b1;
          unique case (in_item.operation)
            OP_WRITE: begin
              if (in_item.first) begin
                wr_rem_nxt = 8'd0;
                if (in_item.block_size != 8'd0) begin
                  if (tx_sum < 9'(DEPTH)) begin
                    if (tx_count_r < CW'(DEPTH)) begin
                      tx_we        = 1'b1;
                      tx_count_nxt = tx_count_r + CW'(1);
                    end
                    wr_rem_nxt  = in_item.block_size - 8'd1;
                    req_en_nxt  = 1'b1;
                    res_ok_nxt  = 1'b1;
                  end else begin
                    tx_drops_nxt = tx_drops_r + 16'd1;
                  end
                end
              end else if (wr_rem_r != 8'd0) begin
                if (tx_count_r < CW'(DEPTH)) begin
                  tx_we        = 1'b1;
                  tx_count_nxt = tx_count_r + CW'(1);
                end
                wr_rem_nxt = wr_rem_r - 8'd1;
                res_ok_nxt = 1'b1;
              end
            end
            OP_READ: begin
              if (rd_ok) begin
                rx_re        = 1'b1;
                rx_raddr     = rx_head_r;
                rx_head_nxt  = wrap_add(rx_head_r, CW'(in_item.block_size));
                rx_count_nxt = rx_count_r - CW'(in_item.block_size);
                res_ok_nxt   = 1'b1;
                res_src_nxt  = SRC_RX;
                if (in_item.block_size != 8'd1) begin
                  res_last_nxt = 1'b0;
                  rd_addr_nxt  = wrap_add(rx_head_r, CW'(1));
                  rd_left_nxt  = CW'(in_item.block_size - 8'd1);
                  state_nxt    = ST_READ;
                end
              end
            end
            OP_RX: begin
              if (rx_count_r < CW'(DEPTH)) begin
                rx_we        = 1'b1;
                rx_count_nxt = rx_count_r + CW'(1);
                res_ok_nxt   = 1'b1;
              end else begin
                rx_drops_nxt = rx_drops_r + 16'd1;
              end
            end
            OP_TX_READY: begin
              if (tx_count_r != CW'(0)) begin
                tx_re        = 1'b1;
                tx_head_nxt  = wrap_add(tx_head_r, CW'(1));
                tx_count_nxt = tx_count_r - CW'(1);
                res_ok_nxt   = 1'b1;
                res_src_nxt  = SRC_TX;
              end else begin
                req_en_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        rx_re        = 1'b1;
        rd_addr_nxt  = wrap_add(rd_addr_r, CW'(1));
        rd_left_nxt  = rd_left_r - CW'(1);
        res_vld_nxt  = 1'b1;
        res_ok_nxt   = 1'b1;
        res_src_nxt  = SRC_RX;
        res_last_nxt = (rd_left_r == CW'(1));
        if (rd_left_r == CW'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      tx_head_r  <= '0;
      tx_count_r <= '0;
      tx_drops_r <= '0;
      rx_head_r  <= '0;
      rx_count_r <= '0;
      rx_drops_r <= '0;
      req_en_r   <= 1'b0;
      wr_rem_r   <= '0;
      res_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tx_head_r  <= tx_head_nxt;
      tx_count_r <= tx_count_nxt;
      tx_drops_r <= tx_drops_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_count_r <= rx_count_nxt;
      rx_drops_r <= rx_drops_nxt;
      req_en_r   <= req_en_nxt;
      wr_rem_r   <= wr_rem_nxt;
      res_vld_r  <= res_vld_nxt;
    end
    rd_addr_r  <= rd_addr_nxt;
    rd_left_r  <= rd_left_nxt;
    res_ok_r   <= res_ok_nxt;
    res_last_r <= res_last_nxt;
    res_src_r  <= res_src_nxt;
  end

  udrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (in_item.data),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rdata)
  );

  udrb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_waddr),
    .wdata (in_item.data),
    .re    (rx_re),
    .raddr (rx_raddr),
    .rdata (rx_rdata)
  );

  assign busy       = (state_r == ST_READ);
  assign out_strobe = res_vld_r;

  always_comb begin
    unique case (res_src_r)
      SRC_TX:  out_res.data_out = tx_rdata;
      SRC_RX:  out_res.data_out = rx_rdata;
      default: out_res.data_out = 8'd0;
    endcase
    out_res.ok            = res_ok_r;
    out_res.last          = res_last_r;
    out_res.tx_request    = req_en_r;
    out_res.tx_fill       = 7'(tx_count_r);
    out_res.rx_fill       = 7'(rx_count_r);
    out_res.tx_drop_count = tx_drops_r;
    out_res.rx_drop_count = rx_drops_r;
  end

endmodule

FILE: sv/udrb_checker.sv
// ----------------------------------------------------------------------------
// udrb_checker
// Port-level checks of the dual ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_dual_ring_buffer_assert.svh"

module udrb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input udrb_pkg::udrb_in_t  in_item,
  input logic                out_strobe,
  input udrb_pkg::udrb_out_t out_res
);
  import udrb_pkg::*;

  `UDRB_ASSERT_NOW(a_fill_bound, out_strobe, (out_res.tx_fill <= 7'(DEPTH)) && (out_res.rx_fill <= 7'(DEPTH)), "fill level beyond depth")
  `UDRB_ASSERT_NEXT(a_single_result, start && !busy && (in_item.operation != OP_READ), out_strobe && out_res.last, "single request gave no final result")
  `UDRB_ASSERT_NEXT(a_busy_streams, busy, out_strobe, "block read stalled")
  `UDRB_ASSERT_NOW(a_fail_zero, out_strobe && !out_res.ok, out_res.data_out == 8'd0, "failed result carries data")
  `UDRB_ASSERT_NEXT(a_block_cont, out_strobe && !out_res.last, out_strobe, "block read broken off")

endmodule

bind uart_dual_ring_buffer udrb_checker u_udrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
